// ===== src/psas_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the arrival statistics block.
package psas_pkg;

  localparam int SOURCES = 8;
  localparam int IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  localparam logic [15:0] FAMILY_IPV4 = 16'd2;
  localparam logic [15:0] MIN_LENGTH = 16'd4;
  localparam logic [31:0] OOB_WORD = 32'hFFFF_FFFF;

  localparam logic [31:0] WINDOW_LEN_RESET = 32'd5000000;
  localparam logic [31:0] GAP_WARN_RESET = 32'd100000;
  localparam logic [31:0] GAP_SEVERE_RESET = 32'd250000;

  localparam logic [1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [1:0] CFG_GAP_WARN = 2'd1;
  localparam logic [1:0] CFG_GAP_SEVERE = 2'd2;

  typedef enum logic [3:0] {
    STAT_WINDOW = 4'd0,
    STAT_IP = 4'd1,
    STAT_PORT = 4'd2,
    STAT_PKTS = 4'd3,
    STAT_BYTES = 4'd4,
    STAT_MAXLEN = 4'd5,
    STAT_FRAGS = 4'd6,
    STAT_OOB = 4'd7,
    STAT_GAPS = 4'd8,
    STAT_AVG = 4'd9,
    STAT_VAR = 4'd10,
    STAT_GAPMAX = 4'd11,
    STAT_WARN = 4'd12,
    STAT_SEVERE = 4'd13
  } stat_code_e;

  typedef struct packed {
    logic load_in;
    logic lookup;
    logic gap;
    logic mul_gap;
    logic update;
    logic wcheck;
    logic scan_init;
    logic scan_step;
    logic [IDX_W-1:0] scan_idx;
    logic div_start;
    logic div_sq;
    logic latch_avg;
    logic latch_msq;
    logic zero_stats;
    logic mul_avg;
    logic calc_var;
    logic emit;
    stat_code_e code;
    logic clear;
  } psas_cmd_t;

  typedef struct packed {
    logic ignore;
    logic found;
    logic win_close;
    logic have_top;
    logic no_gaps;
    logic div_done;
    logic out_busy;
  } psas_status_t;

endpackage

// ===== src/per_source_packet_arrival_stats.sv =====
// Top level of the per-source datagram arrival statistics block.
// An ignored datagram is dropped after the family and length check; a counted one goes through
// lookup, gap, square, update and window check. A window close adds a table scan, two
// divisions (skipped when the source saw no gaps), then 14 report words, each loaded only once
// the output register has emptied; no report is sent when no source saw in-band traffic.
// Throughput: one datagram at a time; a new word is taken only once the sequencer is idle.
// Reset (asynchronous, active low) empties the table, restarts the window and restores
// the configuration registers to their defaults.
module per_source_packet_arrival_stats (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input word: timestamp_us[47:0], src_ip[79:48], src_port[95:80],
  // address_family[111:96], length[127:112], first_word[159:128].
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  // Output word: stat_code[3:0], stat_value[67:4], zero padding above.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  // Configuration writes: index 0 window length, 1 warning gap, 2 severe gap.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  psas_pkg::psas_cmd_t    cmd;
  psas_pkg::psas_status_t st;

  // Configuration must only be written while idle (the block does not enforce this), so it can always be taken.
  assign cfg_ready_o = 1'b1;

  // The controller decides what happens each cycle; the datapath holds the table, statistics and output state.
  psas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  psas_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== src/psas_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module psas_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] div_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted;
  logic        ge;

  always_comb begin
    shifted = {rem_q[31:0], quo_q[63]};
    ge = shifted >= {1'b0, div_q};
    rem_d = ge ? shifted - {1'b0, div_q} : shifted;
    quo_d = {quo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd63;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/psas_dp.sv =====
// Datapath: source table, gap arithmetic, window timing, report maths and output word register.
module psas_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psas_pkg::psas_cmd_t cmd_i,
  output psas_pkg::psas_status_t st_o,
  input  logic [159:0]        in_data_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [71:0]         out_data_o,
  output logic                out_last_o
);

  localparam int N = psas_pkg::SOURCES;
  localparam int IW = psas_pkg::IDX_W;

  logic [47:0] ts_q;
  logic [31:0] ip_q, word_q;
  logic [15:0] port_q, fam_q, len_q;

  logic [31:0] wlen_q, warn_q, severe_q;

  logic [N-1:0] used_q, lav_q;
  logic [31:0] e_ip_q [N];
  logic [15:0] e_port_q [N];
  logic [31:0] pc_q [N];
  logic [31:0] bc_q [N];
  logic [15:0] ml_q [N];
  logic [31:0] fc_q [N];
  logic [31:0] oc_q [N];
  logic [31:0] ib_q [N];
  logic [31:0] gc_q [N];
  logic [63:0] gs_q [N];
  logic [63:0] gss_q [N];
  logic [31:0] gm_q [N];
  logic [31:0] wc_q [N];
  logic [31:0] sc_q [N];
  logic [47:0] la_q [N];

  logic [IW-1:0] idx_q;
  logic          found_q;
  logic [47:0]   gap_q;
  logic [63:0]   prod_q;
  logic [47:0]   ws_q, dur_q;
  logic          started_q;
  logic [IW-1:0] top_q;
  logic [31:0]   top_cnt_q;
  logic          have_q;
  logic [63:0]   avg_q, msq_q, var_q;
  logic          out_valid_q;
  logic [3:0]    out_code_q;
  logic [63:0]   out_value_q;

  logic [N-1:0]  hit;
  logic          hit_any, free_any;
  logic [IW-1:0] hit_idx, free_idx;
  logic [47:0]   gap_d, dur_d, la_sel;
  logic          win_close;
  logic [31:0]   mul_a;
  logic          mul_sat;
  logic [31:0]   g32;
  logic [32:0]   bc_sum;
  logic [64:0]   gs_sum, gss_sum;
  logic          div_done;
  logic [63:0]   quotient;
  logic [63:0]   emit_value;

  always_comb begin
    hit_any = 1'b0;
    free_any = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      hit[i] = used_q[i] && (e_ip_q[i] == ip_q) && (e_port_q[i] == port_q);
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    la_sel = la_q[idx_q];
    gap_d = (ts_q >= la_sel) ? ts_q - la_sel : '0;
    dur_d = (ts_q >= ws_q) ? ts_q - ws_q : '0;
    win_close = started_q && (dur_d >= {16'd0, wlen_q});
    mul_a = cmd_i.mul_avg ? avg_q[31:0] : gap_q[31:0];
    mul_sat = cmd_i.mul_avg ? (|avg_q[63:32]) : (|gap_q[47:32]);
    g32 = (|gap_q[47:32]) ? 32'hFFFF_FFFF : gap_q[31:0];
    bc_sum = {1'b0, bc_q[idx_q]} + {17'd0, len_q};
    gs_sum = {1'b0, gs_q[idx_q]} + {17'd0, gap_q};
    gss_sum = {1'b0, gss_q[idx_q]} + {1'b0, prod_q};
  end

  always_comb begin
    case (cmd_i.code)
      psas_pkg::STAT_WINDOW: emit_value = {16'd0, dur_q};
      psas_pkg::STAT_IP: emit_value = {32'd0, e_ip_q[top_q]};
      psas_pkg::STAT_PORT: emit_value = {48'd0, e_port_q[top_q]};
      psas_pkg::STAT_PKTS: emit_value = {32'd0, pc_q[top_q]};
      psas_pkg::STAT_BYTES: emit_value = {32'd0, bc_q[top_q]};
      psas_pkg::STAT_MAXLEN: emit_value = {48'd0, ml_q[top_q]};
      psas_pkg::STAT_FRAGS: emit_value = {32'd0, fc_q[top_q]};
      psas_pkg::STAT_OOB: emit_value = {32'd0, oc_q[top_q]};
      psas_pkg::STAT_GAPS: emit_value = {32'd0, gc_q[top_q]};
      psas_pkg::STAT_AVG: emit_value = avg_q;
      psas_pkg::STAT_VAR: emit_value = var_q;
      psas_pkg::STAT_GAPMAX: emit_value = {32'd0, gm_q[top_q]};
      psas_pkg::STAT_WARN: emit_value = {32'd0, wc_q[top_q]};
      psas_pkg::STAT_SEVERE: emit_value = {32'd0, sc_q[top_q]};
      default: emit_value = '0;
    endcase
  end

  psas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sq ? gss_q[top_q] : gs_q[top_q]),
    .divisor_i  (gc_q[top_q]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Control state: configuration, valid bits, window and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= psas_pkg::WINDOW_LEN_RESET;
      warn_q <= psas_pkg::GAP_WARN_RESET;
      severe_q <= psas_pkg::GAP_SEVERE_RESET;
      used_q <= '0;
      lav_q <= '0;
      found_q <= 1'b0;
      ws_q <= '0;
      started_q <= 1'b0;
      have_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          psas_pkg::CFG_WINDOW_LEN: wlen_q <= cfg_data_i;
          psas_pkg::CFG_GAP_WARN: warn_q <= cfg_data_i;
          psas_pkg::CFG_GAP_SEVERE: severe_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.lookup) begin
        found_q <= hit_any || free_any;
        if (!hit_any && free_any) begin
          used_q[free_idx] <= 1'b1;
          lav_q[free_idx] <= 1'b0;
        end
      end
      if (cmd_i.update && (word_q != psas_pkg::OOB_WORD)) begin
        lav_q[idx_q] <= 1'b1;
      end
      if (cmd_i.wcheck) begin
        if (!started_q) begin
          started_q <= 1'b1;
          ws_q <= ts_q;
        end else if (win_close) begin
          ws_q <= ts_q;
        end
      end
      if (cmd_i.scan_init) begin
        have_q <= 1'b0;
      end else if (cmd_i.scan_step && used_q[cmd_i.scan_idx] &&
                   (ib_q[cmd_i.scan_idx] != 32'd0) &&
                   (!have_q || ib_q[cmd_i.scan_idx] > top_cnt_q)) begin
        have_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < N; i++) begin
          if (pc_q[i] == 32'd0) begin
            used_q[i] <= 1'b0;
            lav_q[i] <= 1'b0;
          end
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, table and statistics registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ts_q <= in_data_i[47:0];
      ip_q <= in_data_i[79:48];
      port_q <= in_data_i[95:80];
      fam_q <= in_data_i[111:96];
      len_q <= in_data_i[127:112];
      word_q <= in_data_i[159:128];
    end
    if (cmd_i.lookup) begin
      idx_q <= hit_any ? hit_idx : free_idx;
      if (!hit_any && free_any) begin
        e_ip_q[free_idx] <= ip_q;
        e_port_q[free_idx] <= port_q;
        pc_q[free_idx] <= '0;
        bc_q[free_idx] <= '0;
        ml_q[free_idx] <= '0;
        fc_q[free_idx] <= '0;
        oc_q[free_idx] <= '0;
        ib_q[free_idx] <= '0;
        gc_q[free_idx] <= '0;
        gs_q[free_idx] <= '0;
        gss_q[free_idx] <= '0;
        gm_q[free_idx] <= '0;
        wc_q[free_idx] <= '0;
        sc_q[free_idx] <= '0;
        la_q[free_idx] <= '0;
      end
    end
    if (cmd_i.gap) begin
      gap_q <= gap_d;
    end
    if (cmd_i.mul_gap || cmd_i.mul_avg) begin
      prod_q <= mul_sat ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(mul_a) * 64'(mul_a);
    end
    if (cmd_i.update) begin
      if (pc_q[idx_q] != 32'hFFFF_FFFF) pc_q[idx_q] <= pc_q[idx_q] + 32'd1;
      bc_q[idx_q] <= bc_sum[32] ? 32'hFFFF_FFFF : bc_sum[31:0];
      if (len_q > ml_q[idx_q]) ml_q[idx_q] <= len_q;
      if (word_q == psas_pkg::OOB_WORD) begin
        if (oc_q[idx_q] != 32'hFFFF_FFFF) oc_q[idx_q] <= oc_q[idx_q] + 32'd1;
      end else begin
        if (word_q[31] && fc_q[idx_q] != 32'hFFFF_FFFF) fc_q[idx_q] <= fc_q[idx_q] + 32'd1;
        if (ib_q[idx_q] != 32'hFFFF_FFFF) ib_q[idx_q] <= ib_q[idx_q] + 32'd1;
        if (lav_q[idx_q]) begin
          if (gc_q[idx_q] != 32'hFFFF_FFFF) gc_q[idx_q] <= gc_q[idx_q] + 32'd1;
          gs_q[idx_q] <= gs_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : gs_sum[63:0];
          gss_q[idx_q] <= gss_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : gss_sum[63:0];
          if (g32 > gm_q[idx_q]) gm_q[idx_q] <= g32;
          if (gap_q > {16'd0, warn_q} && wc_q[idx_q] != 32'hFFFF_FFFF)
            wc_q[idx_q] <= wc_q[idx_q] + 32'd1;
          if (gap_q > {16'd0, severe_q} && sc_q[idx_q] != 32'hFFFF_FFFF)
            sc_q[idx_q] <= sc_q[idx_q] + 32'd1;
        end
        la_q[idx_q] <= ts_q;
      end
    end
    if (cmd_i.wcheck && win_close) begin
      dur_q <= dur_d;
    end
    if (cmd_i.scan_step && used_q[cmd_i.scan_idx] && (ib_q[cmd_i.scan_idx] != 32'd0) &&
        (!have_q || ib_q[cmd_i.scan_idx] > top_cnt_q)) begin
      top_q <= cmd_i.scan_idx;
      top_cnt_q <= ib_q[cmd_i.scan_idx];
    end
    if (cmd_i.latch_avg) avg_q <= quotient;
    if (cmd_i.latch_msq) msq_q <= quotient;
    if (cmd_i.zero_stats) begin
      avg_q <= '0;
      var_q <= '0;
    end
    if (cmd_i.calc_var) begin
      var_q <= (msq_q > prod_q) ? msq_q - prod_q : '0;
    end
    if (cmd_i.clear) begin
      for (int i = 0; i < N; i++) begin
        pc_q[i] <= '0;
        bc_q[i] <= '0;
        ml_q[i] <= '0;
        fc_q[i] <= '0;
        oc_q[i] <= '0;
        ib_q[i] <= '0;
        gc_q[i] <= '0;
        gs_q[i] <= '0;
        gss_q[i] <= '0;
        gm_q[i] <= '0;
        wc_q[i] <= '0;
        sc_q[i] <= '0;
      end
    end
    if (cmd_i.emit) begin
      out_code_q <= cmd_i.code;
      out_value_q <= emit_value;
    end
  end

  always_comb begin
    st_o.ignore = (fam_q != psas_pkg::FAMILY_IPV4) || (len_q < psas_pkg::MIN_LENGTH);
    st_o.found = found_q;
    st_o.win_close = win_close;
    st_o.have_top = have_q;
    st_o.no_gaps = (gc_q[top_q] == 32'd0);
    st_o.div_done = div_done;
    st_o.out_busy = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = {4'd0, out_value_q, out_code_q};
  assign out_last_o = (out_code_q == psas_pkg::STAT_SEVERE);

endmodule

// ===== src/psas_ctrl.sv =====
// Controller state machine sequencing lookup, update, window check and report.
module psas_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  psas_pkg::psas_status_t st_i,
  output psas_pkg::psas_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_GAP, S_SQUARE, S_UPDATE, S_WCHECK, S_SCAN, S_PICK,
    S_DWAIT1, S_DSTART2, S_DWAIT2, S_ASQ, S_VAR, S_EMIT, S_CLEAR
  } state_e;

  state_e state_q;
  logic [psas_pkg::IDX_W-1:0] scan_q;
  psas_pkg::stat_code_e code_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.scan_idx = scan_q;
    cmd_o.code = code_q;
    case (state_q)
      S_IDLE: cmd_o.load_in = in_valid_i;
      S_CHECK: cmd_o.lookup = !st_i.ignore;
      S_GAP: cmd_o.gap = st_i.found;
      S_SQUARE: cmd_o.mul_gap = 1'b1;
      S_UPDATE: cmd_o.update = 1'b1;
      S_WCHECK: begin
        cmd_o.wcheck = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_PICK: begin
        cmd_o.zero_stats = st_i.have_top && st_i.no_gaps;
        cmd_o.div_start = st_i.have_top && !st_i.no_gaps;
      end
      S_DWAIT1: cmd_o.latch_avg = st_i.div_done;
      S_DSTART2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sq = 1'b1;
      end
      S_DWAIT2: cmd_o.latch_msq = st_i.div_done;
      S_ASQ: cmd_o.mul_avg = 1'b1;
      S_VAR: cmd_o.calc_var = 1'b1;
      S_EMIT: cmd_o.emit = !st_i.out_busy;
      S_CLEAR: cmd_o.clear = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q <= '0;
      code_q <= psas_pkg::STAT_WINDOW;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: state_q <= st_i.ignore ? S_IDLE : S_GAP;
        S_GAP: state_q <= st_i.found ? S_SQUARE : S_WCHECK;
        S_SQUARE: state_q <= S_UPDATE;
        S_UPDATE: state_q <= S_WCHECK;
        S_WCHECK: begin
          scan_q <= '0;
          state_q <= st_i.win_close ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == psas_pkg::IDX_W'(psas_pkg::SOURCES - 1)) state_q <= S_PICK;
        end
        S_PICK: begin
          code_q <= psas_pkg::STAT_WINDOW;
          if (!st_i.have_top) state_q <= S_CLEAR;
          else if (st_i.no_gaps) state_q <= S_EMIT;
          else state_q <= S_DWAIT1;
        end
        S_DWAIT1: if (st_i.div_done) state_q <= S_DSTART2;
        S_DSTART2: state_q <= S_DWAIT2;
        S_DWAIT2: if (st_i.div_done) state_q <= S_ASQ;
        S_ASQ: state_q <= S_VAR;
        S_VAR: state_q <= S_EMIT;
        S_EMIT: begin
          if (!st_i.out_busy) begin
            if (code_q == psas_pkg::STAT_SEVERE) state_q <= S_CLEAR;
            else code_q <= psas_pkg::stat_code_e'(code_q + 4'd1);
          end
        end
        S_CLEAR: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_CHECK)
    else $error("accepted word did not start processing");

  a_last_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && code_q == psas_pkg::STAT_SEVERE && !st_i.out_busy)
      |=> state_q == S_CLEAR)
    else $error("table not cleared after final report word");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> (state_q == S_DWAIT1 || state_q == S_DWAIT2))
    else $error("divider finished outside a wait state");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !st_i.out_busy)
    else $error("report word overwrote a pending word");

endmodule

// ===== tb/per_source_packet_arrival_stats_tb.sv =====
// Self-checking testbench for the per-source datagram arrival statistics block.
`timescale 1ns / 1ps

module per_source_packet_arrival_stats_tb;

  localparam int NSRC = psas_pkg::SOURCES;
  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

  typedef struct {
    psas_pkg::stat_code_e code;
    logic [63:0] value;
    logic last;
  } stat_word_t;

  typedef struct {
    logic used;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] pkts, bytes_seen;
    logic [15:0] maxlen;
    logic [31:0] frags, oob, inband, gaps;
    logic [63:0] gsum, gsq;
    logic [31:0] gmax, warn, severe;
    logic [47:0] last_t;
    logic last_ok;
  } flow_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // Input word: timestamp, src_ip, src_port, address_family, length, first_word.
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // Output word: stat_code, stat_value, padding.
  logic [71:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  per_source_packet_arrival_stats dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: the flow table, the window and the registers.
  flow_t flows[NSRC];
  logic [47:0] win_start;
  logic win_started;
  logic [31:0] win_len, warn_thr, severe_thr;
  stat_word_t expected_words[$];
  int errors = 0;
  logic [47:0] now_us = 0;
  int hold_cycles = 0;   // long receiver hold-off, counted down by the ready process
  bit rx_random = 1'b1;

  task automatic report(input string what);
    errors++;
    $display("%0t: mismatch: %s", $realtime, what);
  endtask

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == ALL32) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL64 : s[63:0];
  endfunction

  function automatic logic [63:0] sat_square(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? ALL64 : v * v;
  endfunction

  function automatic void push_word(input psas_pkg::stat_code_e c, input logic [63:0] v);
    stat_word_t w;
    w.code = c;
    w.value = v;
    w.last = (c == psas_pkg::STAT_SEVERE);
    expected_words.push_back(w);
  endfunction

  function automatic void predict_reset();
    foreach (flows[i]) flows[i] = '{default: '0};
    win_start = '0;
    win_started = 1'b0;
    win_len = psas_pkg::WINDOW_LEN_RESET;
    warn_thr = psas_pkg::GAP_WARN_RESET;
    severe_thr = psas_pkg::GAP_SEVERE_RESET;
  endfunction

  // Closes a window when due and queues the report of the busiest in-band source.
  function automatic void predict_window(input logic [47:0] t);
    int top;
    logic [63:0] dur, avg, msq, asq, vr;
    flow_t keep;
    top = -1;
    if (!win_started) begin
      win_start = t;
      win_started = 1'b1;
      return;
    end
    dur = (t >= win_start) ? 64'(t - win_start) : 64'd0;
    if (dur < {32'd0, win_len}) return;
    win_start = t;
    for (int i = 0; i < NSRC; i++)
      if (flows[i].used && flows[i].inband > 0 &&
          (top < 0 || flows[i].inband > flows[top].inband)) top = i;
    if (top >= 0) begin
      avg = 0;
      vr = 0;
      if (flows[top].gaps != 0) begin
        avg = flows[top].gsum / {32'd0, flows[top].gaps};
        msq = flows[top].gsq / {32'd0, flows[top].gaps};
        asq = sat_square(avg);
        vr = (msq > asq) ? msq - asq : 64'd0;
      end
      push_word(psas_pkg::STAT_WINDOW, dur);
      push_word(psas_pkg::STAT_IP, 64'(flows[top].ip));
      push_word(psas_pkg::STAT_PORT, 64'(flows[top].port));
      push_word(psas_pkg::STAT_PKTS, 64'(flows[top].pkts));
      push_word(psas_pkg::STAT_BYTES, 64'(flows[top].bytes_seen));
      push_word(psas_pkg::STAT_MAXLEN, 64'(flows[top].maxlen));
      push_word(psas_pkg::STAT_FRAGS, 64'(flows[top].frags));
      push_word(psas_pkg::STAT_OOB, 64'(flows[top].oob));
      push_word(psas_pkg::STAT_GAPS, 64'(flows[top].gaps));
      push_word(psas_pkg::STAT_AVG, avg);
      push_word(psas_pkg::STAT_VAR, vr);
      push_word(psas_pkg::STAT_GAPMAX, 64'(flows[top].gmax));
      push_word(psas_pkg::STAT_WARN, 64'(flows[top].warn));
      push_word(psas_pkg::STAT_SEVERE, 64'(flows[top].severe));
    end
    for (int i = 0; i < NSRC; i++) begin
      if (!flows[i].used) continue;
      keep = flows[i];
      flows[i] = '{default: '0};
      if (keep.pkts > 0) begin
        flows[i].used = 1'b1;
        flows[i].ip = keep.ip;
        flows[i].port = keep.port;
        flows[i].last_t = keep.last_t;
        flows[i].last_ok = keep.last_ok;
      end
    end
  endfunction

  function automatic void predict_datagram(input logic [159:0] d);
    logic [47:0] t;
    logic [31:0] ip, fw, g32;
    logic [15:0] port, fam, len;
    logic [63:0] g;
    logic [32:0] bsum;
    int hit;
    t = d[47:0];
    ip = d[79:48];
    port = d[95:80];
    fam = d[111:96];
    len = d[127:112];
    fw = d[159:128];
    hit = -1;
    if (fam != psas_pkg::FAMILY_IPV4 || len < psas_pkg::MIN_LENGTH) return;
    for (int i = 0; i < NSRC; i++)
      if (hit < 0 && flows[i].used && flows[i].ip == ip && flows[i].port == port) hit = i;
    for (int i = 0; i < NSRC; i++)
      if (hit < 0 && !flows[i].used) begin
        hit = i;
        flows[i] = '{default: '0};
        flows[i].used = 1'b1;
        flows[i].ip = ip;
        flows[i].port = port;
      end
    if (hit >= 0) begin
      flows[hit].pkts = sat_inc(flows[hit].pkts);
      bsum = {1'b0, flows[hit].bytes_seen} + {17'd0, len};
      flows[hit].bytes_seen = bsum[32] ? ALL32 : bsum[31:0];
      if (len > flows[hit].maxlen) flows[hit].maxlen = len;
      if (fw == psas_pkg::OOB_WORD) begin
        flows[hit].oob = sat_inc(flows[hit].oob);
      end else begin
        if (fw[31]) flows[hit].frags = sat_inc(flows[hit].frags);
        flows[hit].inband = sat_inc(flows[hit].inband);
        if (flows[hit].last_ok) begin
          g = (t >= flows[hit].last_t) ? 64'(t - flows[hit].last_t) : 64'd0;
          g32 = (g > 64'hFFFF_FFFF) ? ALL32 : g[31:0];
          flows[hit].gaps = sat_inc(flows[hit].gaps);
          flows[hit].gsum = sat_add64(flows[hit].gsum, g);
          flows[hit].gsq = sat_add64(flows[hit].gsq, sat_square(g));
          if (g32 > flows[hit].gmax) flows[hit].gmax = g32;
          if (g > {32'd0, warn_thr}) flows[hit].warn = sat_inc(flows[hit].warn);
          if (g > {32'd0, severe_thr}) flows[hit].severe = sat_inc(flows[hit].severe);
        end
        flows[hit].last_t = t;
        flows[hit].last_ok = 1'b1;
      end
    end
    predict_window(t);
  endfunction

  // Sends one datagram word after a random gap and predicts it on acceptance.
  task automatic send_datagram(input logic [47:0] t, input logic [31:0] ip,
                               input logic [15:0] port, input logic [15:0] fam,
                               input logic [15:0] len, input logic [31:0] fw);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {fw, len, fam, port, ip, t};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_datagram({fw, len, fam, port, ip, t});
    @(negedge clk_i);
  endtask

  task automatic send_v4(input logic [47:0] t, input logic [31:0] ip, input logic [15:0] port,
                         input logic [15:0] len, input logic [31:0] fw);
    send_datagram(t, ip, port, psas_pkg::FAMILY_IPV4, len, fw);
  endtask

  // Waits until every expected word has arrived, then lets the sequencer settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_drained();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      psas_pkg::CFG_WINDOW_LEN: win_len = val;
      psas_pkg::CFG_GAP_WARN: warn_thr = val;
      default: severe_thr = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk_i) begin
    stat_word_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word code %0d", m_axis_tdata[3:0]));
      end else begin
        w = expected_words.pop_front();
        if (m_axis_tdata[3:0] != w.code)
          report($sformatf("code %0d, wanted %0d", m_axis_tdata[3:0], w.code));
        if (m_axis_tdata[67:4] != w.value)
          report($sformatf("code %0d value %0h, wanted %0h", w.code,
                           m_axis_tdata[67:4], w.value));
        if (m_axis_tdata[71:68] != 4'd0) report("padding bits not zero");
        if (m_axis_tlast != w.last)
          report($sformatf("code %0d last %0b", w.code, m_axis_tlast));
      end
    end
  end

  int rx_wait = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else if (!rx_random) begin
      m_axis_tready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      rx_wait = $urandom_range(0, 4);
      m_axis_tready <= (rx_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Advances the clock of the stimulus by dt microseconds and returns it.
  function automatic logic [47:0] tick(input logic [47:0] dt);
    now_us = now_us + dt;
    return now_us;
  endfunction

  task automatic test_directed();
    write_reg(psas_pkg::CFG_WINDOW_LEN, 32'd1000);
    write_reg(psas_pkg::CFG_GAP_WARN, 32'd100);
    write_reg(psas_pkg::CFG_GAP_SEVERE, 32'd300);
    now_us = 48'd10;
    send_v4(tick(0), 32'hC0A8_0001, 16'd5000, 16'd4, 32'h0000_0001);     // opens window
    send_datagram(tick(5), 32'hC0A8_0001, 16'd5000, 16'd3, 16'd100, 0);  // wrong family
    send_v4(tick(5), 32'hC0A8_0001, 16'd5000, 16'd3, 32'h1);             // too short
    send_v4(tick(50), 32'hC0A8_0001, 16'd5000, 16'hFFFF, 32'h8000_0002); // fragment
    send_v4(tick(200), 32'hC0A8_0001, 16'd5000, 16'd100, psas_pkg::OOB_WORD); // out-of-band
    send_v4(tick(400), 32'hC0A8_0001, 16'd5000, 16'd60, 32'h7FFF_FFFF);
    send_v4(tick(10), 32'hFFFF_FFFF, 16'hFFFF, 16'd64, 32'h0);
    send_v4(tick(0), 32'h0000_0000, 16'h0000, 16'd64, 32'hFFFF_FFFE);
    send_v4(tick(400), 32'hC0A8_0001, 16'd5000, 16'd64, 32'h5);          // closes window
    // Only out-of-band traffic: window closes silently.
    send_v4(tick(2000), 32'h0A00_0009, 16'd9, 16'd80, psas_pkg::OOB_WORD);
    // Fill the table, then unknown sources while it is full.
    for (int i = 0; i < NSRC + 1; i++)
      send_v4(tick(1), 32'h0B00_0000 + i, 16'd1, 16'd20, i);
    // Timestamp going back, then a huge gap.
    send_v4(now_us - 48'd30, 32'h0B00_0001, 16'd1, 16'd20, 32'h9);
    send_v4(48'hFFFF_FFFF_FFF0, 32'h0B00_0001, 16'd1, 16'd20, 32'h9);
    now_us = 48'h100;
    wait_drained();
  endtask

  task automatic test_zero_window();
    write_reg(psas_pkg::CFG_WINDOW_LEN, 32'd0);
    write_reg(psas_pkg::CFG_GAP_WARN, 32'd0);
    write_reg(psas_pkg::CFG_GAP_SEVERE, ALL32);
    for (int i = 0; i < 6; i++) send_v4(tick($urandom_range(0, 3)), 32'h1, 16'd2, 16'd8, i);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    int nflows;
    write_reg(psas_pkg::CFG_WINDOW_LEN, $urandom_range(200, 3000));
    write_reg(psas_pkg::CFG_GAP_WARN, $urandom_range(0, 60));
    write_reg(psas_pkg::CFG_GAP_SEVERE, $urandom_range(40, 200));
    nflows = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      logic [31:0] fw;
      logic [15:0] fam, len;
      fw = {$urandom};
      if ($urandom_range(0, 9) == 0) fw = psas_pkg::OOB_WORD;
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
      fam = ($urandom_range(0, 14) == 0) ? 16'($urandom) : psas_pkg::FAMILY_IPV4;
      send_datagram(($urandom_range(0, 19) == 0) ? now_us - 48'd5 : tick($urandom_range(0, 150)),
                    32'hAC10_0000 + $urandom_range(0, nflows), 16'd7000, fam, len, fw);
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering, forcing input stall.
  task automatic test_backpressure();
    write_reg(psas_pkg::CFG_WINDOW_LEN, 32'd1);
    hold_cycles = 600;
    for (int i = 0; i < 10; i++) send_v4(tick(3), 32'h2 + (i % 2), 16'd3, 16'd40, i);
    wait_drained();
    rx_random = 1'b0;
    for (int i = 0; i < 8; i++) send_v4(tick(2), 32'h5, 16'd3, 16'd40, i);
    wait_drained();
    rx_random = 1'b1;
  endtask

  initial begin
    predict_reset();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_zero_window();
    test_random(80);
    test_backpressure();
    test_random(80);
    write_reg(psas_pkg::CFG_WINDOW_LEN, ALL32);
    write_reg(psas_pkg::CFG_GAP_WARN, psas_pkg::WINDOW_LEN_RESET);
    write_reg(psas_pkg::CFG_GAP_SEVERE, 32'd0);
    wait_drained();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
